// ===== rtl/ptw_pkg.sv =====
// ptw_pkg: shared constants, codes and control/status structs for the
// periodic timing wheel. No dependencies; used by every module in rtl/.
`default_nettype none

package ptw_pkg;

  // Field widths fixed by the item format.
  localparam int FUNC_W   = 2;
  localparam int ID_W     = 4;
  localparam int PERIOD_W = 16;
  localparam int KIND_W   = 2;

  // Timer ids are 4 bits, so at most this many entries exist.
  localparam int ID_SPACE = 16;

  // Parameter defaults for the top level.
  localparam int DEF_SLOTS      = 10;
  localparam int DEF_MAX_TIMERS = 16;

  // Operation codes.
  localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_ACK    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EXPIRE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUIET  = 2'd2;

  // Controller -> datapath commands.
  typedef struct packed {
    logic capture;     // latch id and period-1 of the accepted item
    logic tick_start;  // advance position, rewind scan
    logic arm_mul;     // reciprocal multiply
    logic arm_rem;     // quotient and remainder
    logic arm_commit;  // write entry, ack
    logic rm_commit;   // clear entry, ack
    logic scan_step;   // process one entry
    logic scan_close;  // emit final tick result
  } cmd_t;

  // Datapath -> controller status.
  typedef struct packed {
    logic out_free;      // output register can take a result this cycle
    logic scan_last;     // scan index is on the final entry
    logic scan_blocked;  // current entry fires but pending result cannot move
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/periodic_timing_wheel.sv =====
// periodic_timing_wheel: top level of the hashed timing wheel for periodic timers.
// Depends on ptw_pkg, ptw_ctrl and ptw_datapath.
`default_nettype none

// A wheel of SLOTS slots driving up to min(MAX_TIMERS,16) periodic timers.
// One item at a time is taken. An add runs the period through a reciprocal
// multiply (period-1 divided by SLOTS) in ARM_MUL and ARM_REM and returns
// its ack from ARM_WR; a remove acks from REMOVE. A tick advances the
// position and then walks the timer table one entry per cycle, stalling
// while a firing entry's pending expiry cannot reach the output register.
// Each firing timer yields one expiry item in ascending id order and is
// re-armed in the same cycle from its stored slot step and round reload. A
// tick with no expiry yields one quiet item. The last flag marks the final
// result of each input item. Because an expiry is only known to be final
// when the walk ends, it is held back one firing. A new item can be
// accepted while the previous result still sits in the output register.
// Func code 3 is dropped without any result.
module periodic_timing_wheel #(
  parameter int SLOTS      = ptw_pkg::DEF_SLOTS,
  parameter int MAX_TIMERS = ptw_pkg::DEF_MAX_TIMERS
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_valid,
  output logic                           in_ready,
  input  wire  [ptw_pkg::FUNC_W-1:0]     in_func,
  input  wire  [ptw_pkg::ID_W-1:0]       in_timer_id,
  input  wire  [ptw_pkg::PERIOD_W-1:0]   in_period,
  output logic                           out_valid,
  input  wire                            out_ready,
  output logic [ptw_pkg::KIND_W-1:0]     out_result_kind,
  output logic [ptw_pkg::ID_W-1:0]       out_timer_id_res,
  output logic                           out_not_found,
  output logic                           out_last
);
  import ptw_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer: decodes accepted items, paces arm and scan steps
  ptw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_func  (in_func),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Timer table, position, arithmetic and the output register
  ptw_datapath #(
    .SLOTS      (SLOTS),
    .MAX_TIMERS (MAX_TIMERS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_timer_id      (in_timer_id),
    .in_period        (in_period),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_kind  (out_result_kind),
    .out_timer_id_res (out_timer_id_res),
    .out_not_found    (out_not_found),
    .out_last         (out_last)
  );

endmodule

`default_nettype wire

// ===== rtl/ptw_ctrl.sv =====
// ptw_ctrl: sequencing state machine for the periodic timing wheel.
// Depends on ptw_pkg (cmd_t, sts_t, function codes).
`default_nettype none

module ptw_ctrl (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  [ptw_pkg::FUNC_W-1:0]   in_func,
  input  ptw_pkg::sts_t                sts,
  output ptw_pkg::cmd_t                cmd
);
  import ptw_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_ARM_MUL = 7'b0000010,
    ST_ARM_REM = 7'b0000100,
    ST_ARM_WR  = 7'b0001000,
    ST_REMOVE  = 7'b0010000,
    ST_SCAN    = 7'b0100000,
    ST_FINISH  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          case (in_func)
            FUNC_TICK: begin
              cmd.tick_start = 1'b1;
              state_nxt      = ST_SCAN;
            end
            FUNC_ADD:    state_nxt = ST_ARM_MUL;
            FUNC_REMOVE: state_nxt = ST_REMOVE;
            default:     state_nxt = ST_IDLE;  // unused code: dropped
          endcase
        end
      end
      ST_ARM_MUL: begin
        cmd.arm_mul = 1'b1;
        state_nxt   = ST_ARM_REM;
      end
      ST_ARM_REM: begin
        cmd.arm_rem = 1'b1;
        state_nxt   = ST_ARM_WR;
      end
      ST_ARM_WR: begin
        if (sts.out_free) begin
          cmd.arm_commit = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      ST_REMOVE: begin
        if (sts.out_free) begin
          cmd.rm_commit = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (!sts.scan_blocked) begin
          cmd.scan_step = 1'b1;
          if (sts.scan_last) begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.scan_close = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ptw_datapath.sv =====
// ptw_datapath: timer table, wheel position, arm arithmetic and output register.
// Depends on ptw_pkg; driven by ptw_ctrl through cmd_t / sts_t.
`default_nettype none

module ptw_datapath #(
  parameter int SLOTS      = ptw_pkg::DEF_SLOTS,
  parameter int MAX_TIMERS = ptw_pkg::DEF_MAX_TIMERS
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire  [ptw_pkg::ID_W-1:0]       in_timer_id,
  input  wire  [ptw_pkg::PERIOD_W-1:0]   in_period,
  input  ptw_pkg::cmd_t                  cmd,
  output ptw_pkg::sts_t                  sts,
  output logic                           out_valid,
  input  wire                            out_ready,
  output logic [ptw_pkg::KIND_W-1:0]     out_result_kind,
  output logic [ptw_pkg::ID_W-1:0]       out_timer_id_res,
  output logic                           out_not_found,
  output logic                           out_last
);
  import ptw_pkg::*;

  localparam int SW     = $clog2(SLOTS);
  localparam int NT     = (MAX_TIMERS < ID_SPACE) ? MAX_TIMERS : ID_SPACE;
  localparam int RW     = $clog2((65534 / SLOTS) + 1);
  // floor(x / SLOTS) == (x * MAGIC) >> SHIFT for every 16-bit x
  localparam int SHIFT  = PERIOD_W + SW;
  localparam longint unsigned MAGIC = ((64'd1 << SHIFT) + SLOTS - 1) / SLOTS;
  localparam int MAG_W  = PERIOD_W + 1;
  localparam int PROD_W = PERIOD_W + MAG_W;
  localparam int QS_W   = RW + SW + 1;

  localparam logic [MAG_W-1:0] MAGIC_C  = MAG_W'(MAGIC);
  localparam logic [SW:0]      SLOTS_C  = (SW + 1)'(SLOTS);
  localparam logic [SW-1:0]    SLOT_TOP = SW'(SLOTS - 1);
  localparam logic [ID_W:0]    NT_C     = (ID_W + 1)'(NT);
  localparam logic [ID_W-1:0]  IDX_TOP  = ID_W'(NT - 1);

  // Control state
  logic [SW-1:0]     pos_r;
  logic [ID_SPACE-1:0] active_r;
  logic [ID_W-1:0]   idx_r;
  logic              pend_v_r;
  logic              out_valid_r;

  // Payload
  logic [ID_W-1:0]     id_r;
  logic [PERIOD_W-1:0] pm1_r;
  logic [PROD_W-1:0]   prod_r;
  logic [RW-1:0]       quo_r;
  logic [SW-1:0]       rem_r;
  logic [ID_W-1:0]     pend_id_r;
  logic [KIND_W-1:0]   out_kind_r;
  logic [ID_W-1:0]     out_id_r;
  logic                out_nf_r;
  logic                out_last_r;

  // Timer table; undefined until armed
  logic [SW-1:0] slot_r   [ID_SPACE];
  logic [SW-1:0] step_r   [ID_SPACE];
  logic [RW-1:0] reload_r [ID_SPACE];
  logic [RW-1:0] rounds_r [ID_SPACE];

  logic [PERIOD_W-1:0] pm1_c;
  logic [PROD_W-1:0]   prod_c;
  logic [RW-1:0]       quo_c;
  logic [QS_W-1:0]     qs_c;
  logic [PERIOD_W-1:0] diff_c;
  logic [SW-1:0]       step_c;
  logic [SW-1:0]       add_a, add_b;
  logic [SW:0]         sum_c;
  logic [SW-1:0]       wrap_c;
  logic                id_ok, rm_hit;
  logic                hit, fire;
  logic                out_free;
  logic                out_load;
  logic [KIND_W-1:0]   ld_kind;
  logic [ID_W-1:0]     ld_id;
  logic                ld_nf, ld_last;

  assign pm1_c  = (in_period == '0) ? '0 : in_period - 1'b1;
  assign prod_c = pm1_r * MAGIC_C;
  assign quo_c  = prod_r[SHIFT +: RW];
  assign qs_c   = quo_c * SLOTS_C;
  assign diff_c = pm1_r - qs_c[PERIOD_W-1:0];
  assign step_c = (rem_r == SLOT_TOP) ? '0 : rem_r + 1'b1;

  // One modular adder shared by arming and re-arming.
  assign add_a  = cmd.scan_step ? slot_r[idx_r] : pos_r;
  assign add_b  = cmd.scan_step ? step_r[idx_r] : step_c;
  assign sum_c  = {1'b0, add_a} + {1'b0, add_b};
  assign wrap_c = (sum_c >= SLOTS_C) ? SW'(sum_c - SLOTS_C) : sum_c[SW-1:0];

  assign id_ok  = ({1'b0, id_r} < NT_C);
  assign rm_hit = id_ok && active_r[id_r];

  assign hit  = active_r[idx_r] && (slot_r[idx_r] == pos_r);
  assign fire = hit && (rounds_r[idx_r] == '0);

  assign out_free = !out_valid_r || out_ready;

  assign sts.out_free     = out_free;
  assign sts.scan_last    = (idx_r == IDX_TOP);
  assign sts.scan_blocked = fire && pend_v_r && !out_free;

  // Output register load selection
  always_comb begin
    out_load = 1'b0;
    ld_kind  = KIND_ACK;
    ld_id    = id_r;
    ld_nf    = 1'b0;
    ld_last  = 1'b1;
    if (cmd.arm_commit) begin
      out_load = 1'b1;
      ld_nf    = !id_ok;
    end else if (cmd.rm_commit) begin
      out_load = 1'b1;
      ld_nf    = !rm_hit;
    end else if (cmd.scan_step && fire && pend_v_r) begin
      // earlier expiry goes out now, not the final one
      out_load = 1'b1;
      ld_kind  = KIND_EXPIRE;
      ld_id    = pend_id_r;
      ld_last  = 1'b0;
    end else if (cmd.scan_close) begin
      out_load = 1'b1;
      ld_kind  = pend_v_r ? KIND_EXPIRE : KIND_QUIET;
      ld_id    = pend_v_r ? pend_id_r : '0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      active_r    <= '0;
      idx_r       <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.tick_start) begin
        pos_r    <= (pos_r == SLOT_TOP) ? '0 : pos_r + 1'b1;
        idx_r    <= '0;
        pend_v_r <= 1'b0;
      end
      if (cmd.arm_commit && id_ok) begin
        active_r[id_r] <= 1'b1;
      end
      if (cmd.rm_commit && rm_hit) begin
        active_r[id_r] <= 1'b0;
      end
      if (cmd.scan_step) begin
        idx_r <= idx_r + 1'b1;
        if (fire) begin
          pend_v_r <= 1'b1;
        end
      end
      if (cmd.scan_close) begin
        pend_v_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      id_r  <= in_timer_id;
      pm1_r <= pm1_c;
    end
    if (cmd.arm_mul) begin
      prod_r <= prod_c;
    end
    if (cmd.arm_rem) begin
      quo_r <= quo_c;
      rem_r <= diff_c[SW-1:0];
    end
    if (cmd.arm_commit && id_ok) begin
      slot_r[id_r]   <= wrap_c;
      step_r[id_r]   <= step_c;
      reload_r[id_r] <= quo_r;
      rounds_r[id_r] <= quo_r;
    end
    if (cmd.scan_step && hit) begin
      if (fire) begin
        slot_r[idx_r]   <= wrap_c;
        rounds_r[idx_r] <= reload_r[idx_r];
      end else begin
        rounds_r[idx_r] <= rounds_r[idx_r] - 1'b1;
      end
    end
    if (cmd.scan_step && fire) begin
      pend_id_r <= idx_r;
    end
    if (out_load) begin
      out_kind_r <= ld_kind;
      out_id_r   <= ld_id;
      out_nf_r   <= ld_nf;
      out_last_r <= ld_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_kind  = out_kind_r;
  assign out_timer_id_res = out_id_r;
  assign out_not_found    = out_nf_r;
  assign out_last         = out_last_r;

`ifndef SYNTHESIS
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, pos_r} < SLOTS_C))
    else $error("wheel position out of range");

  a_step_unblocked: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_step |-> !sts.scan_blocked)
    else $error("scan advanced while a result was stuck");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> out_free)
    else $error("output register overwritten");

  a_close: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_close |=> (!pend_v_r && out_valid_r && out_last_r))
    else $error("tick close did not leave a final result");
`endif

endmodule

`default_nettype wire
